// File: design/at_modem_link_supervisor_assert.svh
// Assertion macros for the modem link supervisor.
`ifndef AT_MODEM_LINK_SUPERVISOR_ASSERT_SVH
`define AT_MODEM_LINK_SUPERVISOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that the expression holds at every clock edge out of reset.
`define AMLS_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define AMLS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AMLS_ALWAYS(lbl, expr, msg)
`define AMLS_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/at_mls_pkg.sv
`default_nettype none
package at_mls_pkg;

	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_START = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CMD    = 2'd0,
		KIND_BAUD   = 2'd1,
		KIND_CALLER = 2'd2,
		KIND_SENDER = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CMD_AT    = 3'd0,
		CMD_ATE0  = 3'd1,
		CMD_CLIP  = 3'd2,
		CMD_CMGF  = 3'd3,
		CMD_CNMI  = 3'd4,
		CMD_ATH   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		PH_OFFLINE = 2'd0,
		PH_PROBING = 2'd1,
		PH_CONFIG  = 2'd2,
		PH_READY   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_PROBE_RETRY = 3'd0,
		REG_CMD_TIMEOUT = 3'd1,
		REG_CALL_DEDUP  = 3'd2,
		REG_RING_TIMEOUT = 3'd3,
		REG_PROBES_PER_BAUD = 3'd4
	} reg_index_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [15:0] LIT_OK   = "OK";
	localparam logic [31:0] LIT_RING = "RING";
	localparam logic [47:0] LIT_CLIP = "+CLIP:";
	localparam logic [39:0] LIT_CMT  = "+CMT:";

	localparam int unsigned LIT_MAX = 6;

	localparam logic [15:0] RST_PROBE_RETRY  = 16'd5000;
	localparam logic [15:0] RST_CMD_TIMEOUT  = 16'd2000;
	localparam logic [15:0] RST_CALL_DEDUP   = 16'd10000;
	localparam logic [15:0] RST_RING_TIMEOUT = 16'd8000;
	localparam logic [3:0]  RST_PROBES       = 4'd2;

	// Setup commands past this step repeat the last one.
	localparam logic [2:0] LAST_SETUP_STEP = 3'd4;

endpackage
`default_nettype wire

// File: design/at_modem_link_supervisor.sv
// Sequence: a byte other than LF or CR is stored from IDLE; a tick goes through TICK before
// any result; an LF goes through SCAN and DECIDE, then any DEDUP compare or COPY of the number.
// Throughput: one item at a time; s_tready is low while a line, tick or start is handled,
// and a line end walks every stored byte through the one read port of the line memory.
// Reset (arst_n low) clears all control state, timers and lengths; the stores hold garbage
// until written and need no clearing pass, so the block is ready as soon as reset is released.
`default_nettype none
`include "at_modem_link_supervisor_assert.svh"
module at_modem_link_supervisor
	import at_mls_pkg::*;
#(
	parameter int unsigned LINE_MAX     = 256,
	parameter int unsigned NUMBER_MAX   = 32,
	parameter int unsigned BAUD_OPTIONS = 5,
	parameter int unsigned SETUP_STEPS  = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [2:0] command, [5:3] baud_select,
	                                    // [13:6] number_char, [14] link_ready, [15] zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast,   // last result caused by the input transfer
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// Width of line positions and lengths (0..LINE_MAX), and of a line memory address.
	localparam int unsigned LW  = $clog2(LINE_MAX + 1);
	localparam int unsigned AW  = $clog2(LINE_MAX);
	// Width of number lengths (0..NUMBER_MAX), and of a number store address.
	localparam int unsigned NW  = $clog2(NUMBER_MAX + 1);
	localparam int unsigned NAW = $clog2(NUMBER_MAX);
	// Width of the printable-ratio products.
	localparam int unsigned PW  = LW + 4;

	// The sequencer. Bytes are stored from IDLE; a line end runs one pass over the line
	// memory (SCAN), then DECIDE classifies the line. A caller number is compared with the
	// last caller entry by entry (DEDUP), an SMS sender is copied entry by entry (COPY). Results
	// leave through the EM states, one per transfer, whenever the output register is free.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DEDUP,
		ST_COPY,
		ST_TICK,
		ST_EM_BAUD,
		ST_EM_CMD,
		ST_EM_CHR
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] probe_retry_q, cmd_timeout_q, call_dedup_q, ring_timeout_q;
	logic [3:0]  probes_per_baud_q;

	// Link state.
	phase_t      phase_q;
	logic [2:0]  baud_q;
	logic [3:0]  probe_count_q;
	logic [2:0]  setup_step_q;
	logic [31:0] now_q, sent_at_q, last_call_at_q, first_ring_at_q;
	logic        ring_waiting_q, awaiting_body_q;
	logic [LW-1:0] line_len_q;
	logic [NW-1:0] sender_len_q, last_caller_len_q;

	// Memories and small register files.
	logic [7:0] line_mem [LINE_MAX];
	logic [7:0] num_buf [NUMBER_MAX];
	logic [7:0] sender_mem [NUMBER_MAX];
	logic [7:0] caller_mem [NUMBER_MAX];

	// Line scan.
	logic [LW-1:0] rd_q, pos_s1, s_q, e_q;
	logic [LW-1:0] cum_q, pbase_q, pend_q;
	logic          valid_s1, found_q, q1f_q, q2f_q;
	logic [7:0]    rdata_s1;
	logic [LIT_MAX-1:0][7:0] lit_q;
	logic [NW-1:0] nlen_q;

	// Sequencing of results.
	logic [NW-1:0] idx_q, emit_len_q;
	logic          eq_q, chars_after_q;
	kind_t         char_kind_q;
	cmd_t          cmd_q;

	// Output register.
	logic        out_valid_q, out_last_q, out_ready_q;
	kind_t       out_kind_q;
	cmd_t        out_cmd_q;
	logic [2:0]  out_baud_q;
	logic [7:0]  out_char_q;

	logic          s_accept, ofree, out_load;
	mode_t         in_mode;
	logic [7:0]    in_byte;
	logic          is_sp, is_pr, issue;
	logic [LW-1:0] offset, n_len, prn;
	logic [PW-1:0] prn10, n7;
	logic          drop;
	logic [NW-1:0] num_len;
	logic          num_we, sender_we, caller_we;
	logic [31:0]   sub_base, diff;
	logic [7:0]    num_rd, sender_rd;
	logic [3:0]    pc_next;
	logic [2:0]    step_next;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign in_mode  = mode_t'(s_tuser);
	assign in_byte  = s_tdata;
	assign ofree    = !out_valid_q || m_tready;
	// A result is loaded into the output register from any EM state once it is free.
	assign out_load = ofree && (state_q == ST_EM_BAUD || state_q == ST_EM_CMD ||
		state_q == ST_EM_CHR);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_ready_q, out_char_q, out_baud_q, out_cmd_q};

	always_comb begin
		is_sp   = (rdata_s1 == CH_SPACE) || (rdata_s1 >= CH_TAB && rdata_s1 <= CH_CR);
		is_pr   = (rdata_s1 >= CH_SPACE) && (rdata_s1 < CH_DEL);
		offset  = found_q ? (pos_s1 - s_q) : '0;
		issue   = (state_q == ST_SCAN) && (rd_q < line_len_q);
		n_len   = e_q - s_q;
		prn     = pend_q - pbase_q;
		prn10   = PW'(prn) * PW'(10);
		n7      = PW'(n_len) * PW'(7);
		drop    = !found_q || (prn10 < n7);
		num_len = q2f_q ? nlen_q : '0;
		num_we  = (state_q == ST_SCAN) && valid_s1 && q1f_q && !q2f_q &&
			(rdata_s1 != CH_QUOTE) && (nlen_q < NW'(NUMBER_MAX));
		num_rd    = num_buf[idx_q[NAW-1:0]];
		sender_rd = sender_mem[idx_q[NAW-1:0]];
		sender_we = (state_q == ST_COPY) && (idx_q < sender_len_q);
		caller_we = (state_q == ST_EM_CHR) && ofree && (char_kind_q == KIND_CALLER);
		// The one shared subtractor for every elapsed-time check.
		if (state_q == ST_DEDUP) begin
			sub_base = last_call_at_q;
		end else if (phase_q == PH_READY) begin
			sub_base = first_ring_at_q;
		end else begin
			sub_base = sent_at_q;
		end
		diff      = now_q - sub_base;
		pc_next   = probe_count_q + 4'd1;
		step_next = setup_step_q + 3'd1;
	end

	// Line memory: written from IDLE, read once a cycle during the scan.
	always_ff @(posedge clk) begin
		if (s_accept && in_mode == MODE_BYTE && in_byte != CH_LF && in_byte != CH_CR &&
				line_len_q < LW'(LINE_MAX)) begin
			line_mem[line_len_q[AW-1:0]] <= in_byte;
		end
		if (issue) begin
			rdata_s1 <= line_mem[rd_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (num_we) begin
			num_buf[nlen_q[NAW-1:0]] <= rdata_s1;
		end
		if (sender_we) begin
			sender_mem[idx_q[NAW-1:0]] <= num_rd;
		end
		if (caller_we) begin
			caller_mem[idx_q[NAW-1:0]] <= num_rd;
		end
		if (state_q == ST_SCAN && valid_s1 && (found_q || !is_sp) &&
				offset < LW'(LIT_MAX)) begin
			lit_q[offset[2:0]] <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_retry_q     <= RST_PROBE_RETRY;
			cmd_timeout_q     <= RST_CMD_TIMEOUT;
			call_dedup_q      <= RST_CALL_DEDUP;
			ring_timeout_q    <= RST_RING_TIMEOUT;
			probes_per_baud_q <= RST_PROBES;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PROBE_RETRY:     probe_retry_q     <= cfg_data;
				REG_CMD_TIMEOUT:     cmd_timeout_q     <= cfg_data;
				REG_CALL_DEDUP:      call_dedup_q      <= cfg_data;
				REG_RING_TIMEOUT:    ring_timeout_q    <= cfg_data;
				REG_PROBES_PER_BAUD: probes_per_baud_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			phase_q           <= PH_OFFLINE;
			baud_q            <= '0;
			probe_count_q     <= '0;
			setup_step_q      <= '0;
			now_q             <= '0;
			sent_at_q         <= '0;
			last_call_at_q    <= '0;
			first_ring_at_q   <= '0;
			ring_waiting_q    <= 1'b0;
			awaiting_body_q   <= 1'b0;
			line_len_q        <= '0;
			sender_len_q      <= '0;
			last_caller_len_q <= '0;
			rd_q              <= '0;
			pos_s1            <= '0;
			valid_s1          <= 1'b0;
			s_q               <= '0;
			e_q               <= '0;
			cum_q             <= '0;
			pbase_q           <= '0;
			pend_q            <= '0;
			found_q           <= 1'b0;
			q1f_q             <= 1'b0;
			q2f_q             <= 1'b0;
			nlen_q            <= '0;
			idx_q             <= '0;
			emit_len_q        <= '0;
			eq_q              <= 1'b0;
			chars_after_q     <= 1'b0;
			char_kind_q       <= KIND_CALLER;
			cmd_q             <= CMD_AT;
			out_valid_q       <= 1'b0;
			out_last_q        <= 1'b0;
			out_ready_q       <= 1'b0;
			out_kind_q        <= KIND_CMD;
			out_cmd_q         <= CMD_AT;
			out_baud_q        <= '0;
			out_char_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						case (in_mode)
							MODE_BYTE: begin
								if (in_byte == CH_LF) begin
									rd_q     <= '0;
									valid_s1 <= 1'b0;
									found_q  <= 1'b0;
									cum_q    <= '0;
									q1f_q    <= 1'b0;
									q2f_q    <= 1'b0;
									nlen_q   <= '0;
									state_q  <= ST_SCAN;
								end else if (in_byte != CH_CR) begin
									if (line_len_q >= LW'(LINE_MAX)) begin
										line_len_q <= '0;
									end else begin
										line_len_q <= line_len_q + LW'(1);
									end
								end
							end
							MODE_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= ST_TICK;
							end
							MODE_START: begin
								phase_q       <= PH_PROBING;
								cmd_q         <= CMD_AT;
								chars_after_q <= 1'b0;
								sent_at_q     <= now_q;
								state_q       <= ST_EM_BAUD;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					valid_s1 <= issue;
					pos_s1   <= rd_q;
					if (issue) begin
						rd_q <= rd_q + LW'(1);
					end
					if (valid_s1) begin
						cum_q <= cum_q + LW'(is_pr);
						if (!is_sp) begin
							if (!found_q) begin
								found_q <= 1'b1;
								s_q     <= pos_s1;
								pbase_q <= cum_q;
							end
							e_q    <= pos_s1 + LW'(1);
							pend_q <= cum_q + LW'(is_pr);
						end
						if (rdata_s1 == CH_QUOTE) begin
							if (!q1f_q) begin
								q1f_q <= 1'b1;
							end else begin
								q2f_q <= 1'b1;
							end
						end
						if (num_we) begin
							nlen_q <= nlen_q + NW'(1);
						end
					end
					if (!issue && !valid_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					line_len_q <= '0;
					state_q    <= ST_IDLE;
					idx_q      <= '0;
					if (!drop) begin
						if (awaiting_body_q) begin
							awaiting_body_q <= 1'b0;
							if (sender_len_q != '0) begin
								char_kind_q <= KIND_SENDER;
								emit_len_q  <= sender_len_q;
								state_q     <= ST_EM_CHR;
							end
						end else if (n_len == LW'(2) && {lit_q[0], lit_q[1]} == LIT_OK) begin
							if (phase_q == PH_PROBING) begin
								phase_q       <= PH_CONFIG;
								setup_step_q  <= '0;
								cmd_q         <= CMD_ATE0;
								chars_after_q <= 1'b0;
								sent_at_q     <= now_q;
								state_q       <= ST_EM_CMD;
							end else if (phase_q == PH_CONFIG) begin
								setup_step_q <= step_next;
								if (step_next >= 3'(SETUP_STEPS)) begin
									phase_q <= PH_READY;
								end else begin
									cmd_q <= (step_next < LAST_SETUP_STEP) ?
										cmd_t'(step_next + 3'd1) : CMD_CNMI;
									chars_after_q <= 1'b0;
									sent_at_q     <= now_q;
									state_q       <= ST_EM_CMD;
								end
							end
						end else if (n_len == LW'(4) &&
								{lit_q[0], lit_q[1], lit_q[2], lit_q[3]} == LIT_RING) begin
							if (!ring_waiting_q) begin
								ring_waiting_q  <= 1'b1;
								first_ring_at_q <= now_q;
							end
						end else if (n_len >= LW'(6) && {lit_q[0], lit_q[1], lit_q[2],
								lit_q[3], lit_q[4], lit_q[5]} == LIT_CLIP) begin
							ring_waiting_q <= 1'b0;
							if (num_len != '0) begin
								emit_len_q <= num_len;
								eq_q       <= (num_len == last_caller_len_q);
								state_q    <= ST_DEDUP;
							end
						end else if (n_len >= LW'(5) && {lit_q[0], lit_q[1], lit_q[2],
								lit_q[3], lit_q[4]} == LIT_CMT) begin
							sender_len_q    <= num_len;
							awaiting_body_q <= (num_len != '0);
							if (num_len != '0) begin
								state_q <= ST_COPY;
							end
						end
					end
				end
				ST_DEDUP: begin
					// Compare one entry a cycle while the lengths and the entries so far match.
					if (eq_q && idx_q < emit_len_q) begin
						if (num_rd != caller_mem[idx_q[NAW-1:0]]) begin
							eq_q <= 1'b0;
						end
						idx_q <= idx_q + NW'(1);
					end else if (eq_q && diff < {16'd0, call_dedup_q}) begin
						state_q <= ST_IDLE;
					end else begin
						last_caller_len_q <= emit_len_q;
						last_call_at_q    <= now_q;
						sent_at_q         <= now_q;
						cmd_q             <= CMD_ATH;
						chars_after_q     <= 1'b1;
						char_kind_q       <= KIND_CALLER;
						idx_q             <= '0;
						state_q           <= ST_EM_CMD;
					end
				end
				ST_COPY: begin
					if (sender_we) begin
						idx_q <= idx_q + NW'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					state_q <= ST_IDLE;
					case (phase_q)
						PH_PROBING: begin
							if (diff > {16'd0, probe_retry_q}) begin
								sent_at_q     <= now_q;
								cmd_q         <= CMD_AT;
								chars_after_q <= 1'b0;
								if (pc_next >= probes_per_baud_q) begin
									probe_count_q <= '0;
									baud_q <= (baud_q == 3'(BAUD_OPTIONS - 1)) ?
										3'd0 : baud_q + 3'd1;
									line_len_q <= '0;
									state_q    <= ST_EM_BAUD;
								end else begin
									probe_count_q <= pc_next;
									state_q       <= ST_EM_CMD;
								end
							end
						end
						PH_CONFIG: begin
							if (diff > {16'd0, cmd_timeout_q}) begin
								phase_q   <= PH_PROBING;
								sent_at_q <= now_q - {16'd0, probe_retry_q};
							end
						end
						PH_READY: begin
							if (ring_waiting_q && diff > {16'd0, ring_timeout_q}) begin
								ring_waiting_q <= 1'b0;
								sent_at_q      <= now_q;
								cmd_q          <= CMD_ATH;
								chars_after_q  <= 1'b0;
								state_q        <= ST_EM_CMD;
							end
						end
						default: ;
					endcase
				end
				ST_EM_BAUD: begin
					if (ofree) begin
						out_kind_q  <= KIND_BAUD;
						out_cmd_q   <= CMD_AT;
						out_char_q  <= '0;
						out_baud_q  <= baud_q;
						out_ready_q <= (phase_q == PH_READY);
						out_last_q  <= 1'b0;
						state_q     <= ST_EM_CMD;
					end
				end
				ST_EM_CMD: begin
					if (ofree) begin
						out_kind_q  <= KIND_CMD;
						out_cmd_q   <= cmd_q;
						out_char_q  <= '0;
						out_baud_q  <= baud_q;
						out_ready_q <= (phase_q == PH_READY);
						out_last_q  <= !chars_after_q;
						state_q     <= chars_after_q ? ST_EM_CHR : ST_IDLE;
					end
				end
				ST_EM_CHR: begin
					if (ofree) begin
						out_kind_q  <= char_kind_q;
						out_cmd_q   <= CMD_AT;
						out_char_q  <= (char_kind_q == KIND_CALLER) ? num_rd : sender_rd;
						out_baud_q  <= baud_q;
						out_ready_q <= (phase_q == PH_READY);
						out_last_q  <= (idx_q + NW'(1) == emit_len_q);
						idx_q       <= idx_q + NW'(1);
						if (idx_q + NW'(1) == emit_len_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The baud index never leaves the list of rates.
	`AMLS_ALWAYS(a_baud_range, baud_q <= 3'(BAUD_OPTIONS - 1), "baud index out of range")
	// The held line never grows past its limit.
	`AMLS_ALWAYS(a_line_len, line_len_q <= LW'(LINE_MAX), "line length past limit")
	// Number characters are only sent while the index is inside the stored number.
	`AMLS_ALWAYS(a_chr_idx, state_q != ST_EM_CHR || idx_q < emit_len_q, "number index past its length")
	// A command result marked last always leads the block back to accepting items.
	`AMLS_NEXT(a_last_idle, ofree && state_q == ST_EM_CMD && !chars_after_q, state_q == ST_IDLE, "block did not return to idle after its last result")

endmodule
`default_nettype wire

// File: test/tb_at_modem_link_supervisor.sv
`default_nettype none
module tb_at_modem_link_supervisor;
	import at_mls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Longest quiet stretch we expect after a line end: a full line walk plus number copies.
	localparam int SETTLE_CYCLES = 600;
	// Cycles without any transfer before the run is declared hung.
	localparam int HANG_LIMIT = 40000;
	// Length of the single long receiver hold-off.
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] rx;
	} link_item_t;

	typedef struct {
		kind_t      kind;
		cmd_t       cmd;
		logic [2:0] baud;
		logic [7:0] ch;
		logic       ready;
		logic       last;
	} modem_action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
	logic [1:0]  s_tuser = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [2:0] command, [5:3] baud_select, [13:6] number_char,
	                             // [14] link_ready, [15] zero
	logic [1:0]  m_tuser;        // [1:0] kind
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	at_modem_link_supervisor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Traffic waiting to be offered, and modem actions we expect the block to request.
	link_item_t    link_pending[$];
	modem_action_t expected_actions[$];
	modem_action_t step_actions[$];

	int errors = 0;
	int items_sent = 0;
	int actions_seen = 0;
	int send_idle_pct = 38;
	int recv_idle_pct = 54;

	// Mirror of the supervisor's registers and state.
	logic [15:0] probe_retry, cmd_timeout, call_dedup, ring_timeout;
	logic [3:0]  probes_per_baud;
	phase_t      phase;
	logic [2:0]  baud_idx, setup_idx;
	logic [3:0]  probe_cnt;
	logic [31:0] now_ms, cmd_sent_at, last_call_at, first_ring_at;
	logic [7:0]  line_buf[256];
	int          line_len;
	bit          body_pending, ring_pending;
	logic [7:0]  sender_num[32];
	int          sender_len;
	logic [7:0]  last_caller[32];
	int          last_caller_len;

	function automatic void queue_action(kind_t k, cmd_t c, logic [7:0] ch);
		modem_action_t a;
		a.kind = k;
		a.cmd = c;
		a.baud = baud_idx;
		a.ch = ch;
		a.ready = 1'b0;
		a.last = 1'b0;
		step_actions.push_back(a);
	endfunction

	function automatic void issue_command(cmd_t c);
		queue_action(KIND_CMD, c, 8'd0);
		cmd_sent_at = now_ms;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Exact match, or prefix match when asked, of the trimmed line against a keyword.
	function automatic bit line_matches(int s, int n, string kw, bit as_prefix);
		if (as_prefix ? (n < kw.len()) : (n != kw.len()))
			return 0;
		for (int i = 0; i < kw.len(); i++)
			if (line_buf[s + i] != kw[i])
				return 0;
		return 1;
	endfunction

	// First quoted field of the trimmed line, cut to 32 characters.
	function automatic int quoted_number(int s, int n, output logic [7:0] num[32]);
		int q1, q2, len;
		q1 = n;
		q2 = n;
		len = 0;
		for (int i = 0; i < n; i++)
			if (line_buf[s + i] == CH_QUOTE) begin
				q1 = i;
				break;
			end
		if (q1 >= n)
			return 0;
		for (int i = q1 + 1; i < n; i++)
			if (line_buf[s + i] == CH_QUOTE) begin
				q2 = i;
				break;
			end
		if (q2 >= n)
			return 0;
		for (int i = q1 + 1; i < q2 && len < 32; i++)
			num[len++] = line_buf[s + i];
		return len;
	endfunction

	function automatic void take_call(logic [7:0] num[32], int len);
		bit same;
		same = (len == last_caller_len);
		for (int i = 0; i < len && same; i++)
			if (num[i] != last_caller[i])
				same = 0;
		if (same && (now_ms - last_call_at) < {16'd0, call_dedup})
			return;
		for (int i = 0; i < len; i++)
			last_caller[i] = num[i];
		last_caller_len = len;
		last_call_at = now_ms;
		issue_command(CMD_ATH);
		for (int i = 0; i < len; i++)
			queue_action(KIND_CALLER, CMD_AT, num[i]);
	endfunction

	function automatic void finish_line();
		int s, e, n, printable, len;
		logic [7:0] num[32];
		s = 0;
		e = line_len;
		printable = 0;
		while (s < e && is_blank(line_buf[s]))
			s++;
		while (e > s && is_blank(line_buf[e - 1]))
			e--;
		n = e - s;
		if (n == 0)
			return;
		for (int i = s; i < e; i++)
			if (line_buf[i] >= 8'd32 && line_buf[i] < CH_DEL)
				printable++;
		if (printable * 10 < n * 7)
			return;
		// The line after an accepted SMS header is its body, whatever it says.
		if (body_pending) begin
			body_pending = 0;
			for (int i = 0; i < sender_len; i++)
				queue_action(KIND_SENDER, CMD_AT, sender_num[i]);
			return;
		end
		if (line_matches(s, n, "OK", 0)) begin
			if (phase == PH_PROBING) begin
				phase = PH_CONFIG;
				setup_idx = 3'd0;
				issue_command(CMD_ATE0);
			end else if (phase == PH_CONFIG) begin
				setup_idx = setup_idx + 3'd1;
				if (setup_idx >= 3'd4)
					phase = PH_READY;
				else
					issue_command(cmd_t'(setup_idx + 3'd1));
			end
			return;
		end
		if (line_matches(s, n, "RING", 0)) begin
			if (!ring_pending) begin
				ring_pending = 1;
				first_ring_at = now_ms;
			end
			return;
		end
		if (line_matches(s, n, "+CLIP:", 1)) begin
			ring_pending = 0;
			len = quoted_number(s, n, num);
			if (len > 0)
				take_call(num, len);
			return;
		end
		if (line_matches(s, n, "+CMT:", 1)) begin
			sender_len = quoted_number(s, n, num);
			for (int i = 0; i < sender_len; i++)
				sender_num[i] = num[i];
			body_pending = sender_len > 0;
		end
	endfunction

	function automatic void advance_ms();
		now_ms = now_ms + 32'd1;
		case (phase)
			PH_PROBING: begin
				if ((now_ms - cmd_sent_at) > {16'd0, probe_retry}) begin
					probe_cnt = probe_cnt + 4'd1;
					if (probe_cnt >= probes_per_baud) begin
						probe_cnt = 4'd0;
						baud_idx = (baud_idx == 3'd4) ? 3'd0 : baud_idx + 3'd1;
						line_len = 0;
						queue_action(KIND_BAUD, CMD_AT, 8'd0);
					end
					issue_command(CMD_AT);
				end
			end
			PH_CONFIG: begin
				// A setup timeout drops back to probing with the probe already due.
				if ((now_ms - cmd_sent_at) > {16'd0, cmd_timeout}) begin
					phase = PH_PROBING;
					cmd_sent_at = now_ms - {16'd0, probe_retry};
				end
			end
			PH_READY: begin
				if (ring_pending && (now_ms - first_ring_at) > {16'd0, ring_timeout}) begin
					ring_pending = 0;
					issue_command(CMD_ATH);
				end
			end
			default: ;
		endcase
	endfunction

	// Predicts the actions caused by one accepted transfer and queues them.
	function automatic void predict_actions(logic [1:0] mode, logic [7:0] rx);
		step_actions.delete();
		case (mode)
			MODE_BYTE: begin
				if (rx == CH_LF) begin
					finish_line();
					line_len = 0;
				end else if (rx != CH_CR) begin
					if (line_len >= 256)
						line_len = 0;
					else
						line_buf[line_len++] = rx;
				end
			end
			MODE_TICK: advance_ms();
			MODE_START: begin
				phase = PH_PROBING;
				queue_action(KIND_BAUD, CMD_AT, 8'd0);
				issue_command(CMD_AT);
			end
			default: ;
		endcase
		foreach (step_actions[k]) begin
			step_actions[k].ready = (phase == PH_READY);
			step_actions[k].last = (k == step_actions.size() - 1);
			expected_actions.push_back(step_actions[k]);
		end
	endfunction

	// Driver: offers pending items, holding each one until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_actions(s_tuser, s_tdata);
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (link_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser <= link_pending[0].mode;
					s_tdata <= link_pending[0].rx;
					void'(link_pending.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transfer and throttles the result side. Once, after
	// enough results, it holds off for a long stretch so the block backs up its input.
	int  hold_left = 0;
	bit  hold_done = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				actions_seen++;
				if (expected_actions.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: kind %0d data %h last %b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					modem_action_t e;
					e = expected_actions.pop_front();
					if (m_tuser != e.kind) begin
						errors++;
						$display("%0t: kind expected %0d actual %0d", $time, e.kind, m_tuser);
					end
					if (m_tdata[2:0] != e.cmd) begin
						errors++;
						$display("%0t: command expected %0d actual %0d",
							$time, e.cmd, m_tdata[2:0]);
					end
					if (m_tdata[5:3] != e.baud) begin
						errors++;
						$display("%0t: baud_select expected %0d actual %0d",
							$time, e.baud, m_tdata[5:3]);
					end
					if (m_tdata[13:6] != e.ch) begin
						errors++;
						$display("%0t: number_char expected %h actual %h",
							$time, e.ch, m_tdata[13:6]);
					end
					if (m_tdata[14] != e.ready) begin
						errors++;
						$display("%0t: link_ready expected %b actual %b",
							$time, e.ready, m_tdata[14]);
					end
					if (m_tlast != e.last) begin
						errors++;
						$display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && actions_seen >= 60) begin
				hold_done <= 1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: a run with no transfer on either side for too long is hung.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_item(logic [1:0] mode, logic [7:0] rx);
		link_item_t it;
		it.mode = mode;
		it.rx = rx;
		link_pending.push_back(it);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_item(MODE_BYTE, s[i]);
	endtask

	// Ends a line, sometimes with trailing blanks and the usual CR before the LF.
	task automatic add_line_end();
		if ($urandom_range(3) == 0)
			add_item(MODE_BYTE, ($urandom_range(1)) ? CH_SPACE : CH_TAB);
		if ($urandom_range(3) != 0)
			add_item(MODE_BYTE, CH_CR);
		add_item(MODE_BYTE, CH_LF);
	endtask

	// A quoted number from a small pool so repeats hit the dedup window; the long one
	// runs past the 32-character cut. Pool entry four gives an empty pair of quotes.
	task automatic add_number(int pick);
		int len;
		len = (pick == 4) ? 0 : (pick == 3) ? 36 : 3 + pick * 4;
		add_item(MODE_BYTE, CH_QUOTE);
		if (pick == 0)
			add_item(MODE_BYTE, "+");
		for (int i = 0; i < len; i++)
			add_item(MODE_BYTE, 8'd48 + 8'((pick * 7 + i * 3) % 10));
		add_item(MODE_BYTE, CH_QUOTE);
	endtask

	task automatic add_random_traffic(int count);
		int target, sel;
		target = link_pending.size() + count;
		while (link_pending.size() < target) begin
			sel = $urandom_range(99);
			if ($urandom_range(2) == 0)
				add_item(MODE_BYTE, ($urandom_range(1)) ? CH_SPACE : CH_TAB);
			if (sel < 28) begin
				repeat ($urandom_range(6, 1)) add_item(MODE_TICK, 8'($urandom));
			end else if (sel < 45) begin
				add_text("OK");
				add_line_end();
			end else if (sel < 53) begin
				add_text("RING");
				add_line_end();
			end else if (sel < 65) begin
				add_text("+CLIP: ");
				add_number($urandom_range(4));
				add_text(",145");
				add_line_end();
			end else if (sel < 75) begin
				add_text("+CMT: ");
				add_number($urandom_range(4));
				add_text(",,\"24/01/01\"");
				add_line_end();
				if ($urandom_range(3) != 0) begin
					add_text(($urandom_range(1)) ? "hello" : "OK");
					add_line_end();
				end
			end else if (sel < 80) begin
				add_item(MODE_START, 8'($urandom));
			end else if (sel < 92) begin
				// Noise: arbitrary bytes, which may also break the line early.
				repeat ($urandom_range(8, 1)) add_item(MODE_BYTE, 8'($urandom));
				add_line_end();
			end else if (sel < 95) begin
				add_item(2'd3, 8'($urandom));
			end else if (sel < 99) begin
				// A known keyword with its number but no quotes closing it.
				add_text("+CLIP: \"555");
				add_line_end();
			end else begin
				repeat (258) add_item(MODE_BYTE, 8'h41);
				add_text("OK");
				add_line_end();
			end
		end
	endtask

	task automatic wait_idle();
		while (link_pending.size() > 0 || s_tvalid || expected_actions.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_PROBE_RETRY: probe_retry = value;
			REG_CMD_TIMEOUT: cmd_timeout = value;
			REG_CALL_DEDUP: call_dedup = value;
			REG_RING_TIMEOUT: ring_timeout = value;
			REG_PROBES_PER_BAUD: probes_per_baud = value[3:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] pr, logic [15:0] ct, logic [15:0] cd,
		logic [15:0] rt, logic [3:0] ppb);
		write_reg(REG_PROBE_RETRY, pr);
		write_reg(REG_CMD_TIMEOUT, ct);
		write_reg(REG_CALL_DEDUP, cd);
		write_reg(REG_RING_TIMEOUT, rt);
		write_reg(REG_PROBES_PER_BAUD, {12'd0, ppb});
	endtask

	initial begin
		probe_retry = RST_PROBE_RETRY;
		cmd_timeout = RST_CMD_TIMEOUT;
		call_dedup = RST_CALL_DEDUP;
		ring_timeout = RST_RING_TIMEOUT;
		probes_per_baud = RST_PROBES;
		phase = PH_OFFLINE;
		baud_idx = '0;
		setup_idx = '0;
		probe_cnt = '0;
		now_ms = '0;
		cmd_sent_at = '0;
		last_call_at = '0;
		first_ring_at = '0;
		line_len = 0;
		body_pending = 0;
		ring_pending = 0;
		sender_len = 0;
		last_caller_len = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: bring the link up at reset settings, then a call, its repeat, an
		// empty number, an SMS with body, and a few ignored inputs.
		add_item(MODE_START, 8'hFF);
		repeat (5) begin
			add_text("OK");
			add_line_end();
		end
		add_item(2'd3, 8'h00);
		add_item(MODE_BYTE, CH_CR);
		add_text("RING");
		add_line_end();
		add_text("+CLIP: ");
		add_number(1);
		add_line_end();
		add_text("+CLIP: ");
		add_number(1);
		add_line_end();
		add_text("+CLIP: ");
		add_number(4);
		add_line_end();
		add_text("+CMT: ");
		add_number(3);
		add_line_end();
		add_text("hi");
		add_line_end();
		wait_idle();

		// Minimum timeouts: probes, baud steps, setup and ring timeouts fire constantly.
		write_reg(3'd5, 16'hFFFF);
		write_reg(3'd7, 16'h0000);
		write_all(16'd1, 16'd1, 16'd0, 16'd1, 4'd1);
		send_idle_pct = 38;
		recv_idle_pct = 54;
		add_item(MODE_START, 8'h00);
		add_random_traffic(40);
		wait_idle();

		// Maximum settings: timers never expire, calls are always inside the window.
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
		send_idle_pct = 54;
		recv_idle_pct = 38;
		add_random_traffic(35);
		wait_idle();

		// Short random timeouts with full throughput on both sides.
		write_all(16'($urandom_range(6, 1)), 16'($urandom_range(8, 1)),
			16'($urandom_range(30)), 16'($urandom_range(6, 1)), 4'($urandom_range(15, 1)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_item(MODE_START, 8'h00);
		add_random_traffic(35);
		wait_idle();

		$display("Covered %0d input transfers and %0d result transfers over four settings,",
			items_sent, actions_seen);
		$display("including link bring-up, probing, baud stepping, calls, SMS and hang-ups.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
